### rtl/kst_pkg.sv
// Package for the k-th largest stream tracker.
// Shared constants, controller state, datapath op codes and status struct.
// No dependencies.
package kst_pkg;

  // Default heap depth (largest k that can be tracked)
  localparam int MAX_KEEP_DEF = 64;

  // Config register map
  localparam int       ADDR_W         = 3;
  localparam int       KEEP_W         = 7;
  localparam bit [0:0] REG_KEEP_COUNT = 1'b0;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd8;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_UP,
    S_DN_L,
    S_DN_C,
    S_FIN,
    S_OUT
  } state_t;

  // Datapath operation for the current cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_DN_START,
    OP_UP_STEP,
    OP_DN_LEFT,
    OP_DN_STEP,
    OP_WR_FIN,
    OP_PUSH
  } op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic app;           // heap below k entries: append path
    logic repl;          // score beats the root: replace path
    logic app_root;      // heap empty, append lands at the root
    logic first_leaf;    // root has no children
    logic up_move;       // score below the parent just read
    logic up_top;        // parent is the root
    logic dn_move;       // a child is smaller than the score
    logic dn_next_leaf;  // chosen child has no children
    logic out_free;      // output register can take a result
  } stat_t;

endpackage

### rtl/kst_score_if.sv
// Input channel interface: one signed score per transfer.
// Depends on nothing.
interface kst_score_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

### rtl/kst_result_if.sv
// Result channel interface: heap root and filled flag per transfer.
// Depends on nothing.
interface kst_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] kth_value;
  logic               filled;

  modport source (output valid, output kth_value, output filled, input ready);
  modport sink   (input valid, input kth_value, input filled, output ready);
endinterface

### rtl/kst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module kst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/kst_ctrl.sv
// Controller FSM for the tracker: sequences append/sift-up and
// replace/sift-down walks. Depends on kst_pkg.
module kst_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kst_pkg::stat_t st,
  output kst_pkg::op_t   op
);

  kst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      kst_pkg::S_IDLE: begin
        if (in_valid) state_next = kst_pkg::S_START;
      end
      kst_pkg::S_START: begin
        priority if (st.app) begin
          state_next = st.app_root ? kst_pkg::S_OUT : kst_pkg::S_UP;
        end else if (st.repl) begin
          state_next = st.first_leaf ? kst_pkg::S_OUT : kst_pkg::S_DN_L;
        end else begin
          state_next = kst_pkg::S_OUT;
        end
      end
      kst_pkg::S_UP: begin
        if (!st.up_move) state_next = kst_pkg::S_OUT;
        else if (st.up_top) state_next = kst_pkg::S_FIN;
      end
      kst_pkg::S_DN_L: state_next = kst_pkg::S_DN_C;
      kst_pkg::S_DN_C: begin
        priority if (!st.dn_move) state_next = kst_pkg::S_OUT;
        else if (st.dn_next_leaf) state_next = kst_pkg::S_FIN;
        else state_next = kst_pkg::S_DN_L;
      end
      kst_pkg::S_FIN: state_next = kst_pkg::S_OUT;
      kst_pkg::S_OUT: begin
        if (st.out_free) state_next = kst_pkg::S_IDLE;
      end
      default: state_next = kst_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    op       = kst_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      kst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = kst_pkg::OP_LOAD;
      end
      kst_pkg::S_START: begin
        priority if (st.app) op = kst_pkg::OP_APPEND;
        else if (st.repl) op = kst_pkg::OP_DN_START;
        else op = kst_pkg::OP_NONE;
      end
      kst_pkg::S_UP:   op = kst_pkg::OP_UP_STEP;
      kst_pkg::S_DN_L: op = kst_pkg::OP_DN_LEFT;
      kst_pkg::S_DN_C: op = kst_pkg::OP_DN_STEP;
      kst_pkg::S_FIN:  op = kst_pkg::OP_WR_FIN;
      kst_pkg::S_OUT: begin
        if (st.out_free) op = kst_pkg::OP_PUSH;
      end
      default: op = kst_pkg::OP_NONE;
    endcase
  end

endmodule

### rtl/kst_dpath.sv
// Datapath: heap RAM, hole position, held score, root mirror, entry count
// and output register. Depends on kst_pkg and kst_ram.
module kst_dpath #(
  parameter int MAX_KEEP = kst_pkg::MAX_KEEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kst_pkg::op_t               op,
  output kst_pkg::stat_t             st,
  input  logic [kst_pkg::KEEP_W-1:0] keep_count,
  input  logic signed [31:0]         score,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         kth_value,
  output logic                       filled
);

  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int EW = CW + 1;
  localparam int KW = (CW > kst_pkg::KEEP_W) ? CW : kst_pkg::KEEP_W;

  logic [CW-1:0]      cnt;
  logic [AW-1:0]      pos;
  logic signed [31:0] xval;
  logic signed [31:0] lval;
  logic signed [31:0] root;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic signed [31:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic signed [31:0] rdata;

  // Effective k: zero means one, saturate at the heap depth
  logic [KW-1:0] k_ext, k_lim, cnt_k;
  always_comb begin
    k_ext = KW'(keep_count);
    cnt_k = KW'(cnt);
    if (k_ext == '0) k_lim = KW'(1);
    else if (k_ext > KW'(MAX_KEEP)) k_lim = KW'(MAX_KEEP);
    else k_lim = k_ext;
  end

  // Index arithmetic in extended width so child indexes never wrap
  logic [EW-1:0] pos_e, cnt_e, lft_e, rgt_e, best_e, nl_e;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] par, par2, par_cnt, pos_m1, par_m1;
  always_comb begin
    pos_e   = EW'(pos);
    cnt_e   = EW'(cnt);
    lft_e   = (pos_e << 1) + EW'(1);
    rgt_e   = lft_e + EW'(1);
    cnt_m1  = cnt - CW'(1);
    par_cnt = AW'(cnt_m1 >> 1);
    pos_m1  = pos - AW'(1);
    par     = pos_m1 >> 1;
    par_m1  = par - AW'(1);
    par2    = par_m1 >> 1;
  end

  // Sift-down child choice: left held in lval, right on rdata
  logic               l_lt, r_ok, r_lt;
  logic signed [31:0] cand, best_val;
  always_comb begin
    l_lt     = (lft_e < cnt_e) && (lval < xval);
    r_ok     = rgt_e < cnt_e;
    cand     = l_lt ? lval : xval;
    r_lt     = r_ok && (rdata < cand);
    best_val = r_lt ? rdata : lval;
    best_e   = r_lt ? rgt_e : lft_e;
    nl_e     = (best_e << 1) + EW'(1);
  end

  // Status to controller
  always_comb begin
    st.app          = cnt_k < k_lim;
    st.repl         = root < xval;
    st.app_root     = cnt == '0;
    st.first_leaf   = cnt_e <= EW'(1);
    st.up_move      = xval < rdata;
    st.up_top       = par == '0;
    st.dn_move      = l_lt || r_lt;
    st.dn_next_leaf = nl_e >= cnt_e;
    st.out_free     = !out_valid || out_ready;
  end

  // RAM port control per op
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = xval;
    ram_raddr = pos;
    unique case (op)
      kst_pkg::OP_APPEND: begin
        if (cnt == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else begin
          ram_raddr = par_cnt;
        end
      end
      kst_pkg::OP_DN_START: begin
        if (st.first_leaf) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else begin
          ram_raddr = AW'(1);
        end
      end
      kst_pkg::OP_UP_STEP: begin
        ram_we = 1'b1;
        if (st.up_move) begin
          ram_wdata = rdata;
          ram_raddr = par2;
        end
      end
      kst_pkg::OP_DN_LEFT: ram_raddr = AW'(rgt_e);
      kst_pkg::OP_DN_STEP: begin
        ram_we    = 1'b1;
        ram_wdata = st.dn_move ? best_val : xval;
        ram_raddr = AW'(nl_e);
      end
      kst_pkg::OP_WR_FIN: ram_we = 1'b1;
      default: ;
    endcase
  end

  kst_ram #(
    .WIDTH (32),
    .DEPTH (MAX_KEEP)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Working registers
  always_ff @(posedge clk) begin
    unique case (op)
      kst_pkg::OP_LOAD:     xval <= score;
      kst_pkg::OP_APPEND:   pos  <= AW'(cnt);
      kst_pkg::OP_DN_START: pos  <= '0;
      kst_pkg::OP_UP_STEP:  if (st.up_move) pos <= par;
      kst_pkg::OP_DN_LEFT:  lval <= rdata;
      kst_pkg::OP_DN_STEP:  if (st.dn_move) pos <= AW'(best_e);
      default: ;
    endcase
    // root mirror follows every write to entry zero
    if (ram_we && ram_waddr == '0) begin
      root <= ram_wdata;
    end
    if (op == kst_pkg::OP_PUSH) begin
      kth_value <= root;
      filled    <= !st.app;
    end
  end

  // Entry count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == kst_pkg::OP_APPEND) begin
        cnt <= cnt + CW'(1);
      end
      if (op == kst_pkg::OP_PUSH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_KEEP))
    else $error("entry count exceeds heap depth");

  a_wr_held: assert property (@(posedge clk) disable iff (rst)
    (ram_we && op != kst_pkg::OP_APPEND) |-> (EW'(ram_waddr) < cnt_e))
    else $error("heap write outside held entries");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    (op == kst_pkg::OP_PUSH) |-> (cnt != '0))
    else $error("result issued from empty heap");

endmodule

### rtl/kth_largest_stream_tracker_unit.sv
// Top level of the k-th largest stream tracker.
// Depends on kst_pkg, kst_score_if, kst_result_if, kst_ctrl, kst_dpath.
//
// Usage:
//   score_ch  : one signed 32-bit score per transfer (valid/ready).
//   result_ch : one result per score: kth_value is the min-heap root after
//               the update, filled is 1 once the heap holds k entries.
//   APB port  : keep_count at byte address 0 (k, reset 8). Write only while
//               no score is in flight.
// Timing: one score at a time. A dropped score, or one that lands at the root
//   of a heap with no children, goes from the start state straight to the
//   output state. An append adds an S_UP step per parent compared, a
//   replacement S_DN_L and S_DN_C per level visited (left child read, then
//   right child read and compare on the single RAM read port), and either
//   walk adds the final write state S_FIN when it reaches the root or a leaf.
//   The next score is taken on the edge that the result can first transfer.
// Reset empties the heap (entry count to zero, no clearing pass) and sets
//   k to 8. A finished result sits in an output register; the next score is
//   accepted while it waits, and that score's result holds in the final
//   state until the receiver takes the earlier one.
module kth_largest_stream_tracker_unit #(
  parameter int MAX_KEEP = kst_pkg::MAX_KEEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  kst_score_if.sink                  score_ch,
  kst_result_if.source               result_ch
);

  logic [kst_pkg::KEEP_W-1:0] keep_count;
  logic                       cfg_wr;
  kst_pkg::stat_t             st;
  kst_pkg::op_t               op;

  // Config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == kst_pkg::REG_KEEP_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= kst_pkg::KEEP_RESET;
    end else if (cfg_wr) begin
      keep_count <= pwdata[kst_pkg::KEEP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == kst_pkg::REG_KEEP_COUNT) begin
      prdata = 32'(keep_count);
    end
  end

  kst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (score_ch.valid),
    .in_ready (score_ch.ready),
    .st       (st),
    .op       (op)
  );

  kst_dpath #(
    .MAX_KEEP (MAX_KEEP)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .st         (st),
    .keep_count (keep_count),
    .score      (score_ch.score),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .kth_value  (result_ch.kth_value),
    .filled     (result_ch.filled)
  );

endmodule

### bench/kth_largest_stream_tracker_unit_tb.sv
// Testbench for the k-th largest stream tracker: drives scores and keep_count
// writes, predicts each heap root in a scoreboard class and checks every result.
// Depends on kst_pkg, kst_score_if, kst_result_if and the tracker top level.
module kth_largest_stream_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH    = kst_pkg::MAX_KEEP_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [kst_pkg::ADDR_W-1:0] KEEP_ADDR = {kst_pkg::REG_KEEP_COUNT, 2'b00};
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;

  typedef logic [kst_pkg::KEEP_W-1:0] keep_t;

  typedef struct packed {
    logic signed [31:0] kth_value;
    logic               filled;
  } rank_t;

  // Min-heap of the kept scores plus the queue of roots still to come out
  class kth_scoreboard;
    logic signed [31:0] heap [HEAP_DEPTH];
    int unsigned        held;
    keep_t              keep;
    rank_t              roots_q[$];
    int                 errors;

    function new();
      foreach (heap[i]) heap[i] = '0;
      held   = 0;
      keep   = kst_pkg::KEEP_RESET;
      errors = 0;
    endfunction

    function void set_keep(keep_t v);
      keep = v;
    endfunction

    // keep_count zero acts as one, anything past the heap depth saturates
    function int unsigned rank_limit();
      if (keep == 0) return 1;
      if (keep > HEAP_DEPTH) return HEAP_DEPTH;
      return keep;
    endfunction

    function logic signed [31:0] root();
      return heap[0];
    endfunction

    function int pending();
      return roots_q.size();
    endfunction

    // Update the heap with one accepted score and queue the resulting root
    function void note_score(logic signed [31:0] s);
      int unsigned        k;
      int unsigned        pos;
      int unsigned        up;
      int unsigned        lc;
      int unsigned        rc;
      int unsigned        best;
      logic signed [31:0] t;
      rank_t              r;
      k = rank_limit();
      if (held < k) begin
        // append and sift up
        heap[held] = s;
        pos = held;
        held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap[pos] >= heap[up]) break;
          t = heap[pos]; heap[pos] = heap[up]; heap[up] = t;
          pos = up;
        end
      end else if (s > heap[0]) begin
        // replace the root and sift down over every held entry
        heap[0] = s;
        pos = 0;
        forever begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          best = pos;
          if (lc < held && heap[lc] < heap[best]) best = lc;
          if (rc < held && heap[rc] < heap[best]) best = rc;
          if (best == pos) break;
          t = heap[pos]; heap[pos] = heap[best]; heap[best] = t;
          pos = best;
        end
      end
      r.kth_value = heap[0];
      r.filled    = (held >= k);
      roots_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] v, logic f);
      rank_t e;
      if (roots_q.size() == 0) begin
        $display("%0t: unexpected result, kth_value %0d filled %0b", $time, v, f);
        errors++;
        return;
      end
      e = roots_q.pop_front();
      if (v !== e.kth_value) begin
        $display("%0t: kth_value expected %0d got %0d", $time, e.kth_value, v);
        errors++;
      end
      if (f !== e.filled) begin
        $display("%0t: filled expected %0b got %0b", $time, e.filled, f);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [kst_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  bit          rx_steady;
  int          stall_left;

  kth_scoreboard tracker = new();

  kst_score_if  score_ch ();
  kst_result_if result_ch ();

  kth_largest_stream_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .score_ch  (score_ch),
    .result_ch (result_ch)
  );

  always #10 clk = ~clk;

  // Run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: short random stalls with the odd long one, or always ready
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (rx_steady) begin
      result_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                : $urandom_range(0, 3);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Result check on every transfer
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
      tracker.check_result(result_ch.kth_value, result_ch.filled);
  end

  // One score transfer; the predictor is updated on acceptance
  task automatic send_score(input logic signed [31:0] s);
    score_ch.valid <= 1'b1;
    score_ch.score <= s;
    do @(posedge clk); while (score_ch.ready !== 1'b1);
    tracker.note_score(s);
  endtask

  task automatic sender_gap(input int cycles);
    score_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every expected root has come out, then let the block settle
  task automatic drain_results();
    score_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of keep_count: setup cycle, then access until pready
  task automatic write_keep(input keep_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEEP_ADDR;
    pwdata  <= {{(32-kst_pkg::KEEP_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_keep(v);
  endtask

  initial begin
    int                 keep_plan[$];
    int                 n;
    int                 burst_left;
    int                 b;
    bit                 tx_steady;
    logic signed [31:0] s;
    logic signed [31:0] r;
    logic signed [31:0] ramp;

    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    score_ch.valid  <= 1'b0;
    score_ch.score  <= '0;
    rx_steady       = 1'b1;
    ramp            = -32'sd1000000;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill the default k of 8 with the extremes, then drops and
    // replacements, including a score equal to the root
    send_score(SCORE_MAX);
    send_score(SCORE_MIN);
    send_score(32'sd0);
    send_score(-32'sd1);
    send_score(32'sd1);
    send_score(32'sd100);
    send_score(-32'sd100);
    send_score(32'sd50);
    send_score(tracker.root());
    send_score(32'sd5);
    send_score(SCORE_MIN);
    send_score(SCORE_MAX);
    send_score(SCORE_MAX);
    send_score(tracker.root());
    send_score(tracker.root() - 1);
    send_score(tracker.root() + 1);
    send_score(32'sd0);
    drain_results();

    // Lowered below the count, raised, zero, full depth, above the depth
    keep_plan = '{1, 20, 0, 64, 127, 3, 65, 64};
    repeat (4) keep_plan.push_back($urandom_range(0, 127));

    foreach (keep_plan[p]) begin
      write_keep(keep_t'(keep_plan[p]));
      rx_steady  = ($urandom_range(0, 3) == 0);
      tx_steady  = ($urandom_range(0, 3) == 0);
      n          = $urandom_range(38, 54);
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          4: begin
            case ($urandom_range(0, 4))
              0: s = SCORE_MIN;
              1: s = SCORE_MAX;
              2: s = 32'sd0;
              3: s = -32'sd1;
              default: s = 32'sd1;
            endcase
          end
          5: s = $signed($urandom_range(0, 15)) - 32'sd8;
          6: s = tracker.root();
          7: begin
            ramp = ramp + $signed($urandom_range(1, 1000));
            s = ramp;
          end
          8: begin
            r = tracker.root();
            s = (r == SCORE_MAX) ? r : r + 1;
          end
          9: begin
            b = $urandom_range(0, 31);
            s = $urandom_range(0, 1) ? (32'sd1 <<< b) : ~(32'sd1 <<< b);
          end
          default: s = $urandom;
        endcase
        send_score(s);

        // mid-phase pause until the block has caught up
        if (i == n / 2 && p % 3 == 1) begin
          drain_results();
        end else if (!tx_steady) begin
          burst_left--;
          if (burst_left == 0) begin
            sender_gap($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
          end
        end
      end
      drain_results();
    end

    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
